/* src/dlb_pkg.sv */
package dlb_pkg;

  localparam int COUNT_WIDTH   = 16;
  localparam int TIMEOUT_WIDTH = 24;

  typedef logic signed [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [TIMEOUT_WIDTH-1:0]      tmo_t;

  localparam cnt_t CNT_ONE  = cnt_t'(1);
  localparam cnt_t CNT_MONE = cnt_t'(-1);

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_BLINK     = 3'd1,
    CMD_SET_RED   = 3'd2,
    CMD_SET_GREEN = 3'd3,
    CMD_RESET     = 3'd4,
    CMD_DEACT     = 3'd5,
    CMD_WAKE      = 3'd6,
    CMD_INIT      = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    MODE_OFF         = 4'd0,
    MODE_RED_OFF     = 4'd1,
    MODE_GREEN_OFF   = 4'd2,
    MODE_RED_FAST    = 4'd3,
    MODE_GREEN_FAST  = 4'd4,
    MODE_RED_SLOW    = 4'd5,
    MODE_GREEN_SLOW  = 4'd6,
    MODE_RG_SLOW_ALT = 4'd7,
    MODE_RG_FAST_ALT = 4'd8,
    MODE_RG_SLOW     = 4'd9,
    MODE_RG_FAST     = 4'd10,
    MODE_WAKE        = 4'd11,
    MODE_RED_CONST   = 4'd12,
    MODE_GREEN_CONST = 4'd13,
    MODE_NO_CHANGE   = 4'd14,
    MODE_NONE        = 4'd15
  } mode_e;

  // configuration register indexes
  localparam logic [2:0] CFG_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_FAST_ON   = 3'd1;
  localparam logic [2:0] CFG_FAST_OFF  = 3'd2;
  localparam logic [2:0] CFG_SLOW_ON   = 3'd3;
  localparam logic [2:0] CFG_SLOW_OFF  = 3'd4;
  localparam logic [2:0] CFG_BRIEF_ON  = 3'd5;
  localparam logic [2:0] CFG_BRIEF_OFF = 3'd6;
  localparam logic [2:0] CFG_WAKE_ON   = 3'd7;

  localparam logic [23:0] CFG_TIMEOUT_RST   = 24'd600000;
  localparam logic [14:0] CFG_FAST_ON_RST   = 15'd25;
  localparam logic [14:0] CFG_FAST_OFF_RST  = 15'd25;
  localparam logic [14:0] CFG_SLOW_ON_RST   = 15'd250;
  localparam logic [14:0] CFG_SLOW_OFF_RST  = 15'd250;
  localparam logic [14:0] CFG_BRIEF_ON_RST  = 15'd15;
  localparam logic [14:0] CFG_BRIEF_OFF_RST = 15'd50;
  localparam logic [14:0] CFG_WAKE_ON_RST   = 15'd12;

  // one led channel
  typedef struct packed {
    logic level;
    cnt_t cnt;
    cnt_t on_len;
    cnt_t off_len;
    logic hold;
  } chan_t;

  // configuration after conversion to internal widths
  typedef struct packed {
    tmo_t timeout;
    cnt_t fast_on;
    cnt_t fast_gap;
    cnt_t slow_on;
    cnt_t slow_gap;
    cnt_t blip_on;
    cnt_t blip_gap;
    cnt_t wake_on;
  } cfg_t;

  function automatic cnt_t to_cnt(logic [14:0] v);
    return cnt_t'({17'd0, v});
  endfunction

  function automatic tmo_t to_tmo(logic [23:0] v);
    return tmo_t'({8'd0, v});
  endfunction

endpackage

/* src/dlb_channel.sv */
module dlb_channel (
  input  dlb_pkg::chan_t chan_i,
  output dlb_pkg::chan_t chan_o
);
  import dlb_pkg::*;

  cnt_t cnt_step;
  logic lvl_step;

  always_comb begin
    lvl_step = chan_i.level;
    cnt_step = chan_i.cnt;
    if (chan_i.cnt > CNT_ONE) begin
      lvl_step = 1'b1;
      cnt_step = chan_i.cnt - CNT_ONE;
    end else if (chan_i.cnt < CNT_MONE) begin
      lvl_step = 1'b0;
      cnt_step = chan_i.cnt + CNT_ONE;
    end
  end

  always_comb begin
    chan_o = chan_i;
    if (chan_i.cnt != '0 && !chan_i.hold) begin
      chan_o.level = lvl_step;
      chan_o.cnt   = cnt_step;
      // end of a phase: lit goes dark, or stays lit when there is no off period; dark goes lit
      if (cnt_step == CNT_ONE) begin
        chan_o.cnt = (chan_i.off_len != '0) ? -chan_i.off_len : chan_i.on_len;
      end else if (cnt_step == CNT_MONE) begin
        chan_o.cnt = chan_i.on_len;
      end
    end
  end

endmodule

/* src/dual_led_blink_controller.sv */
// channel  | signals                                      | direction
// ---------+----------------------------------------------+----------
// in       | in_valid_i in_stall_o command_i mode_i        | in
//          | reload_timeout_i level_i                      |
// out      | out_valid_o out_stall_i red_led_o green_led_o | out
//          | is_active_o                                   |
// cfg      | cfg_we_i cfg_idx_i cfg_data_i                 | in
//
// one item per cycle while in_stall_o is low: the full state update is done in
// the accept cycle from the state registers, the result is registered in out_q or skid_q
// an output register plus one skid entry: in_stall_o rises only when the skid
// entry is full, i.e. after two results wait on a stalled output
// asynchronous active-low reset loads the register reset values, clears state
module dual_led_blink_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [3:0]  mode_i,
  input  logic        reload_timeout_i,
  input  logic        level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        red_led_o,
  output logic        green_led_o,
  output logic        is_active_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  import dlb_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    logic  wake;
    mode_e last_red;
    mode_e last_green;
    mode_e last_both;
    tmo_t  timeout;
    logic  tick_en;
  } st_t;

  typedef struct packed {
    logic red;
    logic green;
    logic active;
  } res_t;

  logic [23:0] cfg_timeout_q;
  logic [14:0] cfg_fast_on_q, cfg_fast_off_q, cfg_slow_on_q, cfg_slow_off_q;
  logic [14:0] cfg_brief_on_q, cfg_brief_off_q, cfg_wake_on_q;
  cfg_t        cfg_c;

  st_t   st_q, st_d;
  chan_t red_tick, green_tick;
  tmo_t  tmo_dec;
  cmd_e  cmd;
  mode_e mode;

  res_t res_d, out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic accept_in, out_go;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_timeout_q   <= CFG_TIMEOUT_RST;
      cfg_fast_on_q   <= CFG_FAST_ON_RST;
      cfg_fast_off_q  <= CFG_FAST_OFF_RST;
      cfg_slow_on_q   <= CFG_SLOW_ON_RST;
      cfg_slow_off_q  <= CFG_SLOW_OFF_RST;
      cfg_brief_on_q  <= CFG_BRIEF_ON_RST;
      cfg_brief_off_q <= CFG_BRIEF_OFF_RST;
      cfg_wake_on_q   <= CFG_WAKE_ON_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT:   cfg_timeout_q   <= cfg_data_i;
        CFG_FAST_ON:   cfg_fast_on_q   <= cfg_data_i[14:0];
        CFG_FAST_OFF:  cfg_fast_off_q  <= cfg_data_i[14:0];
        CFG_SLOW_ON:   cfg_slow_on_q   <= cfg_data_i[14:0];
        CFG_SLOW_OFF:  cfg_slow_off_q  <= cfg_data_i[14:0];
        CFG_BRIEF_ON:  cfg_brief_on_q  <= cfg_data_i[14:0];
        CFG_BRIEF_OFF: cfg_brief_off_q <= cfg_data_i[14:0];
        CFG_WAKE_ON:   cfg_wake_on_q   <= cfg_data_i[14:0];
        default:       cfg_timeout_q   <= cfg_timeout_q;
      endcase
    end
  end

  always_comb begin
    cfg_c.timeout  = to_tmo(cfg_timeout_q);
    cfg_c.fast_on  = to_cnt(cfg_fast_on_q);
    cfg_c.fast_gap = to_cnt(cfg_fast_off_q);
    cfg_c.slow_on  = to_cnt(cfg_slow_on_q);
    cfg_c.slow_gap = to_cnt(cfg_slow_off_q);
    cfg_c.blip_on  = to_cnt(cfg_brief_on_q);
    cfg_c.blip_gap = to_cnt(cfg_brief_off_q);
    cfg_c.wake_on  = to_cnt(cfg_wake_on_q);
  end

  function automatic chan_t set_chan(chan_t ch, cnt_t on, cnt_t off, logic dark);
    chan_t r;
    r         = ch;
    r.on_len  = on;
    r.off_len = off;
    r.cnt     = dark ? -on : on;
    r.hold    = 1'b0;
    return r;
  endfunction

  function automatic st_t blink(st_t s, mode_e m, logic rl, cfg_t c);
    st_t  r;
    logic is_red, is_green, is_both, changed;
    r = s;
    if (rl) r.timeout = c.timeout;
    // after timeout, unless reloaded here, only the off mode gets through
    if (m != MODE_NO_CHANGE && !r.wake && !(r.timeout == '0 && m != MODE_OFF)) begin
      is_red   = (m == MODE_RED_OFF) || (m == MODE_RED_FAST) ||
                 (m == MODE_RED_SLOW) || (m == MODE_RED_CONST);
      is_green = (m == MODE_GREEN_OFF) || (m == MODE_GREEN_FAST) ||
                 (m == MODE_GREEN_SLOW) || (m == MODE_GREEN_CONST);
      is_both  = !is_red && !is_green;
      if (is_red && rl) r.last_red = MODE_NONE;
      changed = (is_red && m != r.last_red) || (is_green && m != r.last_green) ||
                (is_both && m != r.last_both);
      if (changed) begin
        unique case (m)
          MODE_OFF: begin
            r.red.cnt     = '0;
            r.green.cnt   = '0;
            r.red.level   = 1'b0;
            r.green.level = 1'b0;
          end
          MODE_RED_OFF: begin
            r.red.level = 1'b0;
            r.red.cnt   = '0;
          end
          MODE_GREEN_OFF: begin
            r.green.level = 1'b0;
            r.green.cnt   = '0;
          end
          MODE_RED_FAST:   r.red   = set_chan(r.red, c.blip_on, c.blip_gap, 1'b0);
          MODE_GREEN_FAST: r.green = set_chan(r.green, c.blip_on, c.blip_gap, 1'b0);
          // red slow runs on the fast on period
          MODE_RED_SLOW:   r.red   = set_chan(r.red, c.fast_on, c.slow_gap, 1'b0);
          MODE_GREEN_SLOW: r.green = set_chan(r.green, c.slow_on, c.slow_gap, 1'b0);
          MODE_RG_SLOW_ALT: begin
            r.green = set_chan(r.green, c.slow_on, c.slow_gap, 1'b1);
            r.red   = set_chan(r.red, c.slow_on, c.slow_gap, 1'b0);
          end
          MODE_RG_FAST_ALT: begin
            r.green = set_chan(r.green, c.fast_on, c.fast_gap, 1'b1);
            r.red   = set_chan(r.red, c.fast_on, c.fast_gap, 1'b0);
          end
          MODE_RG_SLOW: begin
            r.green = set_chan(r.green, c.slow_on, c.slow_gap, 1'b0);
            r.red   = set_chan(r.red, c.slow_on, c.slow_gap, 1'b0);
          end
          MODE_RG_FAST: begin
            r.green = set_chan(r.green, c.fast_on, c.fast_gap, 1'b0);
            r.red   = set_chan(r.red, c.fast_on, c.fast_gap, 1'b0);
          end
          MODE_WAKE: begin
            r.green       = set_chan(r.green, c.wake_on, '0, 1'b0);
            r.red         = set_chan(r.red, c.wake_on, '0, 1'b0);
            r.red.level   = 1'b1;
            r.green.level = 1'b1;
          end
          MODE_RED_CONST:   r.red   = set_chan(r.red, c.slow_on, '0, 1'b0);
          MODE_GREEN_CONST: r.green = set_chan(r.green, c.slow_on, '0, 1'b0);
          default: ;
        endcase
        r.tick_en = 1'b1;
      end
      if (is_red) begin
        r.last_red = m;
      end else if (is_green) begin
        r.last_green = m;
      end else begin
        r.last_both  = m;
        r.last_red   = m;
        r.last_green = m;
      end
    end
    return r;
  endfunction

  function automatic st_t reset_cmd(st_t s, cfg_t c);
    st_t r;
    r            = blink(s, MODE_OFF, 1'b0, c);
    r.red.hold   = 1'b0;
    r.green.hold = 1'b0;
    r.last_red   = MODE_NONE;
    r.last_green = MODE_NONE;
    r.last_both  = MODE_NONE;
    r.timeout    = c.timeout;
    return r;
  endfunction

  // state after reset: all clear, timeout at its reset reload
  function automatic st_t st_init();
    st_t r;
    r         = '0;
    r.timeout = to_tmo(CFG_TIMEOUT_RST);
    return r;
  endfunction

  dlb_channel u_red (
    .chan_i (st_q.red),
    .chan_o (red_tick)
  );

  dlb_channel u_green (
    .chan_i (st_q.green),
    .chan_o (green_tick)
  );

  assign cmd     = cmd_e'(command_i);
  assign mode    = mode_e'(mode_i);
  assign tmo_dec = st_q.timeout - tmo_t'(1);

  always_comb begin
    st_d = st_q;
    unique case (cmd)
      CMD_TICK: begin
        if (st_q.tick_en) begin
          if (st_q.wake) begin
            st_d.red.level   = 1'b1;
            st_d.green.level = 1'b1;
          end else if (st_q.timeout != '0) begin
            st_d.timeout = tmo_dec;
            if (tmo_dec == '0) begin
              st_d.red.level   = 1'b0;
              st_d.green.level = 1'b0;
            end else begin
              st_d.red   = red_tick;
              st_d.green = green_tick;
            end
          end
        end
      end
      CMD_BLINK: st_d = blink(st_q, mode, reload_timeout_i, cfg_c);
      CMD_SET_RED: begin
        if (st_q.timeout != '0) begin
          st_d.red.hold  = 1'b1;
          st_d.last_red  = MODE_NONE;
          st_d.red.level = level_i;
        end
      end
      CMD_SET_GREEN: begin
        if (st_q.timeout != '0) begin
          st_d.green.hold  = 1'b1;
          st_d.green.level = level_i;
        end
      end
      CMD_RESET: st_d = reset_cmd(st_q, cfg_c);
      CMD_DEACT: begin
        st_d.tick_en     = 1'b0;
        st_d.red.level   = 1'b0;
        st_d.green.level = 1'b0;
        st_d.red.hold    = 1'b1;
        st_d.green.hold  = 1'b1;
        st_d.last_red    = MODE_NONE;
        st_d.timeout     = '0;
      end
      CMD_WAKE: begin
        st_d.wake = level_i;
        if (level_i) begin
          st_d.timeout = cfg_c.timeout;
          if (!st_q.wake) begin
            st_d.red.level   = 1'b1;
            st_d.green.level = 1'b1;
          end
        end
      end
      CMD_INIT: begin
        if (st_q.wake) begin
          if (mode != MODE_OFF) st_d.timeout = cfg_c.timeout;
        end else begin
          st_d.tick_en = 1'b0;
          st_d         = reset_cmd(st_d, cfg_c);
          st_d.tick_en = 1'b1;
          if (mode != MODE_OFF) st_d = blink(st_d, mode, 1'b1, cfg_c);
        end
      end
      default: st_d = st_q;
    endcase
  end

  assign res_d.red    = st_d.red.level;
  assign res_d.green  = st_d.green.level;
  assign res_d.active = (st_d.timeout != '0) && st_d.tick_en;

  assign in_stall_o = skid_valid_q;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign out_go     = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= st_init();
    end else if (accept_in) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_go) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_go) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept_in) begin
        out_q <= res_d;
      end
    end else if (accept_in) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_led_o   = out_q.red;
  assign green_led_o = out_q.green;
  assign is_active_o = out_q.active;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output result");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> out_valid_q)
    else $error("accepted item produced no result");

  a_wake_tick_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && cmd == CMD_TICK && st_q.wake && st_q.tick_en)
      |=> (st_q.red.level && st_q.green.level))
    else $error("tick under wake override left an led dark");

  a_deact_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && cmd == CMD_DEACT) |=> (!st_q.tick_en && st_q.timeout == '0))
    else $error("deactivate left the block active");

  a_timeout_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && cmd == CMD_TICK && st_q.timeout == '0) |=> (st_q.timeout == '0))
    else $error("tick revived an expired timeout");
`endif

endmodule
